// ===== rtl/load_cell_adc_serial_reader_assert.svh =====
// assertion macros for the load cell converter serial reader
`ifndef LOAD_CELL_ADC_SERIAL_READER_ASSERT_SVH
`define LOAD_CELL_ADC_SERIAL_READER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LCADC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lcadc check failed");

// next-cycle implication, checked outside reset
`define LCADC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcadc check failed");

`endif

// ===== rtl/lcadc_pkg.sv =====
// shared types and constants for the load cell converter serial reader
`timescale 1ns / 1ps
`default_nettype none

package lcadc_pkg;

    localparam int DATA_BITS = 24;

    // configuration register indexes
    localparam logic [1:0] REG_CHIP_TYPE   = 2'd0;
    localparam logic [1:0] REG_GAIN        = 2'd1;
    localparam logic [1:0] REG_HALF_PERIOD = 2'd2;
    localparam logic [1:0] REG_TIMEOUT     = 2'd3;

    // read status codes
    localparam logic [1:0] STATUS_NONE    = 2'd0;
    localparam logic [1:0] STATUS_DONE    = 2'd1;
    localparam logic [1:0] STATUS_TIMEOUT = 2'd2;

    typedef struct packed {
        logic req_type;
        logic data_pin_level;
    } in_item_t;

    typedef struct packed {
        logic                        serial_clock_level;
        logic [1:0]                  read_status;
        logic signed [DATA_BITS-1:0] sample_value;
    } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/load_cell_adc_serial_reader.sv =====
// load cell converter serial reader: top level with sequencer and result register
// Each input item is one tick of pin timing and produces exactly one result item
// carrying the serial clock level for that tick, a read status and the sample.
// A start request arms the reader, which waits for a falling edge on the data
// pin (conversion ready) or times out after timeout_ticks waiting ticks. It then
// drives 24 serial clock pulses of half_period_ticks per phase, sampling one bit
// MSB first on the last tick of each high phase, followed by gain_setting + 1
// gain-select pulses when chip_type is 0. The sign-extended sample is reported
// with status done on the tick that ends the last low phase.
// Throughput is one item per cycle while the output is not stalled by m_ready:
// the whole state update for a tick is one registered step of the sequencer,
// and its result lands in a single output register that is refilled in the
// same cycle it is drained. The result is valid in the cycle after acceptance.
// Configuration writes take effect the cycle after cfg_wr_en, also in the
// middle of a read, and are meant to happen while no item is in flight.
`timescale 1ns / 1ps
`default_nettype none

module load_cell_adc_serial_reader (
    input  wire                        aclk,
    input  wire                        aresetn,
    // configuration write port
    input  wire                        cfg_wr_en,
    input  wire  [1:0]                 cfg_index,
    input  wire  [31:0]                cfg_wdata,
    // tick items in
    input  wire                        s_valid,
    output logic                       s_ready,
    input  wire lcadc_pkg::in_item_t   s_data,
    // result items out
    output logic                       m_valid,
    input  wire                        m_ready,
    output lcadc_pkg::out_item_t       m_data
);

    // sequencer phase codes
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_WAIT  = 3'd1;
    localparam logic [2:0] PH_HIGH  = 3'd2;
    localparam logic [2:0] PH_LOW   = 3'd3;
    localparam logic [2:0] PH_XHIGH = 3'd4;
    localparam logic [2:0] PH_XLOW  = 3'd5;

    localparam logic [4:0] BITS_TOTAL = 5'(lcadc_pkg::DATA_BITS);

    // configuration registers
    logic        chip_type_reg;
    logic [1:0]  gain_setting_reg;
    logic [15:0] half_period_reg;
    logic [31:0] timeout_reg;

    // sequencer state
    logic [2:0]                      phase_reg,      phase_next;
    logic                            prev_data_reg,  prev_data_next;
    logic [4:0]                      bit_cnt_reg,    bit_cnt_next;
    logic [lcadc_pkg::DATA_BITS-1:0] shift_reg,      shift_next;
    logic [15:0]                     phase_tmr_reg,  phase_tmr_next;
    logic [31:0]                     wait_tmr_reg,   wait_tmr_next;
    logic [1:0]                      xpulse_cnt_reg, xpulse_cnt_next;

    // result register
    logic                 m_valid_reg;
    lcadc_pkg::out_item_t m_data_reg, m_data_next;

    logic        s_fire;
    logic        finish;
    logic [15:0] half_eff;
    logic [15:0] phase_tmr_inc;
    logic        phase_end;
    logic [31:0] timeout_eff;
    logic [31:0] wait_tmr_inc;
    logic        falling_edge;

    // output slot frees up in the same cycle it is taken
    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // config write, no handshake
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chip_type_reg    <= 1'b0;
            gain_setting_reg <= 2'd0;
            half_period_reg  <= 16'd100;
            timeout_reg      <= 32'd50000000;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                lcadc_pkg::REG_CHIP_TYPE:   chip_type_reg    <= cfg_wdata[0];
                lcadc_pkg::REG_GAIN:        gain_setting_reg <= cfg_wdata[1:0];
                lcadc_pkg::REG_HALF_PERIOD: half_period_reg  <= cfg_wdata[15:0];
                lcadc_pkg::REG_TIMEOUT:     timeout_reg      <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // zero half period and zero timeout both behave as one
    assign half_eff      = (half_period_reg == 16'd0) ? 16'd1 : half_period_reg;
    assign timeout_eff   = (timeout_reg == 32'd0) ? 32'd1 : timeout_reg;
    assign phase_tmr_inc = phase_tmr_reg + 16'd1;
    assign phase_end     = (phase_tmr_inc >= half_eff) || (phase_tmr_inc == 16'd0);
    assign wait_tmr_inc  = wait_tmr_reg + 32'd1;
    assign falling_edge  = prev_data_reg && !s_data.data_pin_level;

    always_comb begin
        phase_next      = phase_reg;
        bit_cnt_next    = bit_cnt_reg;
        shift_next      = shift_reg;
        phase_tmr_next  = phase_tmr_reg;
        wait_tmr_next   = wait_tmr_reg;
        xpulse_cnt_next = xpulse_cnt_reg;
        prev_data_next  = s_data.data_pin_level;
        finish          = 1'b0;

        m_data_next.serial_clock_level = 1'b0;
        m_data_next.read_status        = lcadc_pkg::STATUS_NONE;
        m_data_next.sample_value       = '0;

        case (phase_reg)
            PH_IDLE: begin
                if (s_data.req_type) begin
                    phase_next    = PH_WAIT;
                    wait_tmr_next = 32'd0;
                end
            end
            PH_WAIT: begin
                // edge wins over a timeout on the same tick
                if (falling_edge) begin
                    phase_next     = PH_HIGH;
                    phase_tmr_next = 16'd0;
                    bit_cnt_next   = 5'd0;
                    shift_next     = '0;
                end else begin
                    wait_tmr_next = wait_tmr_inc;
                    if ((wait_tmr_inc >= timeout_eff) || (wait_tmr_inc == 32'd0)) begin
                        m_data_next.read_status = lcadc_pkg::STATUS_TIMEOUT;
                        phase_next              = PH_IDLE;
                        wait_tmr_next           = 32'd0;
                    end
                end
            end
            PH_HIGH: begin
                m_data_next.serial_clock_level = 1'b1;
                phase_tmr_next = phase_end ? 16'd0 : phase_tmr_inc;
                if (phase_end) begin
                    // sample at the end of the high phase, msb first
                    shift_next   = {shift_reg[lcadc_pkg::DATA_BITS-2:0],
                                    s_data.data_pin_level};
                    bit_cnt_next = bit_cnt_reg + 5'd1;
                    phase_next   = PH_LOW;
                end
            end
            PH_LOW: begin
                phase_tmr_next = phase_end ? 16'd0 : phase_tmr_inc;
                if (phase_end) begin
                    if (bit_cnt_reg < BITS_TOTAL) begin
                        phase_next = PH_HIGH;
                    end else if (!chip_type_reg) begin
                        xpulse_cnt_next = gain_setting_reg;
                        phase_next      = PH_XHIGH;
                    end else begin
                        finish = 1'b1;
                    end
                end
            end
            PH_XHIGH: begin
                m_data_next.serial_clock_level = 1'b1;
                phase_tmr_next = phase_end ? 16'd0 : phase_tmr_inc;
                if (phase_end) begin
                    phase_next = PH_XLOW;
                end
            end
            PH_XLOW: begin
                phase_tmr_next = phase_end ? 16'd0 : phase_tmr_inc;
                if (phase_end) begin
                    if (xpulse_cnt_reg == 2'd0) begin
                        finish = 1'b1;
                    end else begin
                        xpulse_cnt_next = xpulse_cnt_reg - 2'd1;
                        phase_next      = PH_XHIGH;
                    end
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase

        // report the sign-extended sample and go idle
        if (finish) begin
            m_data_next.read_status  = lcadc_pkg::STATUS_DONE;
            m_data_next.sample_value = $signed(shift_reg);
            phase_next               = PH_IDLE;
            bit_cnt_next             = 5'd0;
        end
    end

    // state advances once per accepted tick item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            prev_data_reg  <= 1'b1;
            bit_cnt_reg    <= 5'd0;
            shift_reg      <= '0;
            phase_tmr_reg  <= 16'd0;
            wait_tmr_reg   <= 32'd0;
            xpulse_cnt_reg <= 2'd0;
        end else if (s_fire) begin
            phase_reg      <= phase_next;
            prev_data_reg  <= prev_data_next;
            bit_cnt_reg    <= bit_cnt_next;
            shift_reg      <= shift_next;
            phase_tmr_reg  <= phase_tmr_next;
            wait_tmr_reg   <= wait_tmr_next;
            xpulse_cnt_reg <= xpulse_cnt_next;
        end
    end

    // result register valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_data_reg <= m_data_next;
        end
    end

    // checks on the sequencer
    `include "load_cell_adc_serial_reader_assert.svh"

    // idle and waiting never carry a partial bit count
    `LCADC_ASSERT_NOW(a_idle_cnt_clear, aclk, aresetn, (phase_reg == PH_IDLE || phase_reg == PH_WAIT), (bit_cnt_reg == 5'd0))

    // never more bits shifted than a sample holds
    `LCADC_ASSERT_NOW(a_bit_cnt_range, aclk, aresetn, 1'b1, (bit_cnt_reg <= BITS_TOTAL))

    // a finishing tick produces a done result and returns to idle
    `LCADC_ASSERT_NEXT(a_finish_result, aclk, aresetn, (s_fire && finish), (m_valid_reg && m_data_reg.read_status == lcadc_pkg::STATUS_DONE && phase_reg == PH_IDLE))

endmodule

`default_nettype wire
